// ----- rtl/core/hrlp_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// hrlp_pkg
// Shared types, codes and helpers of the hex record line parser.
// ----------------------------------------------------------------------------
package hrlp_pkg;

    // result kinds
    localparam logic [2:0] KIND_DATA    = 3'd0;
    localparam logic [2:0] KIND_OK      = 3'd1;
    localparam logic [2:0] KIND_BAD     = 3'd2;
    localparam logic [2:0] KIND_END     = 3'd3;
    localparam logic [2:0] KIND_INVALID = 3'd4;
    localparam logic [2:0] KIND_TIMEOUT = 3'd5;

    // input opcodes
    localparam logic OP_CHAR = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // configuration register indexes
    localparam int unsigned CFG_INDEX_W = 8;
    localparam logic [CFG_INDEX_W-1:0] CFG_POLL_LIMIT = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_LINE_LIMIT = 8'd1;

    localparam logic [7:0] POLL_LIMIT_RST = 8'd50;
    localparam logic [7:0] LINE_LIMIT_RST = 8'd255;

    // characters
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;

    // character positions within a line
    localparam logic [7:0] POS_COUNT_END = 8'd2;
    localparam logic [7:0] POS_ADDR_END  = 8'd6;
    localparam logic [7:0] POS_TYPE_HI   = 8'd7;
    localparam logic [7:0] POS_TYPE_LO   = 8'd8;
    localparam logic [9:0] POS_DATA_LEN  = 10'd11;

    // record type as far as known
    localparam logic [1:0] PH_NONE  = 2'd0;
    localparam logic [1:0] PH_DATA  = 2'd1;
    localparam logic [1:0] PH_END   = 2'd2;
    localparam logic [1:0] PH_OTHER = 2'd3;

    // line flag bits
    localparam int unsigned FLAG_BAD_START = 0;
    localparam int unsigned FLAG_NON_HEX   = 1;
    localparam int unsigned FLAG_TYPE_ZERO = 2;

    typedef struct packed {
        logic       opcode;
        logic [7:0] char_code;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  data_byte;
        logic [15:0] load_address;
        logic [7:0]  byte_count;
        logic        end_seen;
        logic        last;
    } t_out_item;

    // results of one item, first result in res0
    typedef struct packed {
        logic [1:0] num;
        t_out_item  res0;
        t_out_item  res1;
    } t_push;

    // hex digit value, bit 4 set when the character is a hex digit
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] v;
        v = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = {1'b1, c[3:0]};
        end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
            v = {1'b1, c[3:0] + 4'd9};
        end
        return v;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/core/hex_record_line_parser_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// hex_record_line_parser_top
// Intel HEX line parser: serial characters and idle ticks in, data bytes and
// one status per line out.
// ----------------------------------------------------------------------------
// Each input transfer is either a received character or an idle tick.
// The parser takes one transfer per clock cycle and updates its line state in
// that same cycle; a transfer gives zero, one or two results (a data byte
// and/or the line status), which go into a four-entry result queue that
// feeds the output channel. The input is ready whenever the queue has room
// for two results, so with the output taken every cycle the block sustains
// one transfer per cycle; a run of two-result transfers is limited by the
// single output port to one result per cycle. Data bytes carry their address
// (record address plus byte index); each line ends with exactly one status.
// end_seen is sticky once an end-of-file record is seen and only reset
// clears it. Configuration writes are accepted in every cycle and must only
// be issued while the block is idle.
// ----------------------------------------------------------------------------
module hex_record_line_parser_top
    import hrlp_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // item input
    input  wire logic                   i_in_valid,
    output logic                        o_in_ready,
    input  wire t_in_item               i_in_item,
    // result output
    output logic                        o_out_valid,
    input  wire logic                   i_out_ready,
    output t_out_item                   o_out_item,
    // configuration writes
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [7:0]             i_cfg_data
);

    logic [7:0] r_poll_limit;
    logic [7:0] r_line_limit;
    logic       in_fire;
    logic       room;
    t_push      push;

    // config registers, writes beyond the list are dropped
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poll_limit <= POLL_LIMIT_RST;
            r_line_limit <= LINE_LIMIT_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_POLL_LIMIT: r_poll_limit <= i_cfg_data;
                CFG_LINE_LIMIT: r_line_limit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input transfer when the queue can take a full two-result burst
    assign o_in_ready = room;
    assign in_fire    = i_in_valid && room;

    hrlp_parse u_parse (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (in_fire),
        .i_item       (i_in_item),
        .i_poll_limit (r_poll_limit),
        .i_line_limit (r_line_limit),
        .o_push       (push)
    );

    hrlp_out_fifo u_out_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push_en (in_fire),
        .i_push    (push),
        .o_room    (room),
        .o_valid   (o_out_valid),
        .i_ready   (i_out_ready),
        .o_item    (o_out_item)
    );

endmodule
`default_nettype wire

// ----- rtl/core/hrlp_parse.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// hrlp_parse
// Per-line parse state and the combinational update for one transfer.
// ----------------------------------------------------------------------------
module hrlp_parse
    import hrlp_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_fire,
    input  wire t_in_item i_item,
    input  wire logic [7:0] i_poll_limit,
    input  wire logic [7:0] i_line_limit,
    output t_push         o_push
);

    logic [1:0]  r_phase, n_phase;
    logic [7:0]  r_pos, n_pos;
    logic [7:0]  r_polls, n_polls;
    logic [3:0]  r_high, n_high;
    logic [7:0]  r_count, n_count;
    logic [15:0] r_addr, n_addr;
    logic [7:0]  r_idx, n_idx;
    logic [2:0]  r_flags, n_flags;
    logic        r_done, n_done;

    logic [4:0]  hv;
    logic        is_char;
    logic        ended;
    logic        hex_used;
    logic [2:0]  end_kind;

    always_comb begin
        hv       = hex_value(i_item.char_code);
        is_char  = (i_item.opcode == OP_CHAR);
        n_phase  = r_phase;
        n_pos    = r_pos;
        n_polls  = r_polls;
        n_high   = r_high;
        n_count  = r_count;
        n_addr   = r_addr;
        n_idx    = r_idx;
        n_flags  = r_flags;
        n_done   = r_done;
        ended    = 1'b0;
        hex_used = 1'b0;
        end_kind = KIND_INVALID;
        o_push   = '0;

        if (i_poll_limit == 8'd0) begin
            o_push.num  = 2'd1;
            o_push.res0 = '{kind: KIND_TIMEOUT, data_byte: 8'd0, load_address: r_addr,
                            byte_count: r_count, end_seen: r_done, last: 1'b1};
            ended = 1'b1;
        end else begin
            if (is_char) begin
                if (r_pos == 8'd0) begin
                    if (i_item.char_code != CH_COLON) n_flags[FLAG_BAD_START] = 1'b1;
                end else if (!r_flags[FLAG_BAD_START]) begin
                    if (r_pos <= POS_COUNT_END) begin
                        n_count  = {r_count[3:0], hv[3:0]};
                        hex_used = 1'b1;
                    end else if (r_pos <= POS_ADDR_END) begin
                        n_addr   = {r_addr[11:0], hv[3:0]};
                        hex_used = 1'b1;
                    end else if (r_pos == POS_TYPE_HI) begin
                        if (i_item.char_code == CH_ZERO) n_flags[FLAG_TYPE_ZERO] = 1'b1;
                    end else if (r_pos == POS_TYPE_LO) begin
                        if (r_flags[FLAG_TYPE_ZERO] && i_item.char_code == CH_ZERO) begin
                            n_phase = PH_DATA;
                        end else if (r_flags[FLAG_TYPE_ZERO] && i_item.char_code == CH_ONE) begin
                            n_phase = PH_END;
                        end else begin
                            n_phase = PH_OTHER;
                        end
                    end else if (r_phase == PH_DATA && r_idx < r_count
                                 && i_item.char_code != CH_LF) begin
                        hex_used = 1'b1;
                        // odd positions carry the high digit
                        if (r_pos[0]) begin
                            n_high = hv[3:0];
                        end else begin
                            o_push.num  = 2'd1;
                            o_push.res0 = '{kind: KIND_DATA, data_byte: {r_high, hv[3:0]},
                                            load_address: r_addr + {8'd0, r_idx},
                                            byte_count: r_count, end_seen: r_done,
                                            last: 1'b0};
                            n_idx = r_idx + 8'd1;
                        end
                    end
                    if (hex_used && !hv[4]) n_flags[FLAG_NON_HEX] = 1'b1;
                end

                n_pos = r_pos + 8'd1;
                ended = (i_item.char_code == CH_LF) || (i_line_limit <= 8'd1)
                        || (n_pos >= i_line_limit - 8'd1);

                if (n_flags[FLAG_BAD_START]) begin
                    end_kind = KIND_BAD;
                end else if (n_phase == PH_END) begin
                    end_kind = KIND_END;
                    n_done   = 1'b1;
                end else if (n_phase == PH_DATA && i_item.char_code == CH_LF
                             && !n_flags[FLAG_NON_HEX]
                             && {2'b00, r_pos} == POS_DATA_LEN + {1'b0, n_count, 1'b0}) begin
                    end_kind = KIND_OK;
                end else begin
                    end_kind = KIND_INVALID;
                end
                if (!ended) n_done = r_done;
            end

            if (!ended) begin
                n_polls = r_polls + 8'd1;
                if (n_polls >= i_poll_limit) begin
                    ended    = 1'b1;
                    end_kind = KIND_TIMEOUT;
                end
            end

            if (ended) begin
                if (o_push.num == 2'd0) begin
                    o_push.num  = 2'd1;
                    o_push.res0 = '{kind: end_kind, data_byte: 8'd0, load_address: n_addr,
                                    byte_count: n_count, end_seen: n_done, last: 1'b1};
                end else begin
                    o_push.num  = 2'd2;
                    o_push.res1 = '{kind: end_kind, data_byte: 8'd0, load_address: n_addr,
                                    byte_count: n_count, end_seen: n_done, last: 1'b1};
                end
            end else if (o_push.num != 2'd0) begin
                o_push.res0.last = 1'b1;
            end
        end

        // new line after any status
        if (ended) begin
            n_phase = PH_NONE;
            n_pos   = 8'd0;
            n_polls = 8'd0;
            n_high  = 4'd0;
            n_count = 8'd0;
            n_addr  = 16'd0;
            n_idx   = 8'd0;
            n_flags = 3'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_NONE;
            r_pos   <= 8'd0;
            r_polls <= 8'd0;
            r_high  <= 4'd0;
            r_count <= 8'd0;
            r_addr  <= 16'd0;
            r_idx   <= 8'd0;
            r_flags <= 3'd0;
            r_done  <= 1'b0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_polls <= n_polls;
            r_high  <= n_high;
            r_count <= n_count;
            r_addr  <= n_addr;
            r_idx   <= n_idx;
            r_flags <= n_flags;
            r_done  <= n_done;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/hrlp_out_fifo.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// hrlp_out_fifo
// Four-entry result queue taking up to two results per cycle.
// ----------------------------------------------------------------------------
module hrlp_out_fifo
    import hrlp_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_push_en,
    input  wire t_push     i_push,
    output logic           o_room,
    output logic           o_valid,
    input  wire logic      i_ready,
    output t_out_item      o_item
);

    t_out_item  r_mem [4];
    logic [1:0] r_wr_ptr, n_wr_ptr;
    logic [1:0] r_rd_ptr, n_rd_ptr;
    logic [2:0] r_count, n_count;
    logic [1:0] push_num;
    logic       pop;

    assign push_num = i_push_en ? i_push.num : 2'd0;
    assign o_valid  = (r_count != 3'd0);
    assign o_item   = r_mem[r_rd_ptr];
    assign o_room   = (r_count <= 3'd2);
    assign pop      = o_valid && i_ready;

    always_comb begin
        n_wr_ptr = r_wr_ptr + push_num;
        n_rd_ptr = r_rd_ptr + {1'b0, pop};
        n_count  = r_count + {1'b0, push_num} - {2'b00, pop};
    end

    always_ff @(posedge i_clk) begin
        if (push_num != 2'd0) r_mem[r_wr_ptr] <= i_push.res0;
        if (push_num == 2'd2) r_mem[r_wr_ptr + 2'd1] <= i_push.res1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 2'd0;
            r_rd_ptr <= 2'd0;
            r_count  <= 3'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule
`default_nettype wire

// ----- dv/tb_hex_record_line_parser_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hex_record_line_parser_top
// Self-checking bench for the Intel HEX line parser.
// ----------------------------------------------------------------------------
// Characters and idle ticks are fed through the item channel from a queue of
// pending transfers. An in-bench copy of the parser state predicts the data
// bytes and line statuses that each accepted transfer causes, and every
// result transfer is checked field by field against the oldest prediction.
// The run starts with a short directed line set and then goes through
// several limit settings with mostly well-formed records carrying random
// content, mixed with corrupted, truncated and noisy lines. Both channels
// idle in random bursts except in the final phase.
// ----------------------------------------------------------------------------
module tb_hex_record_line_parser_top;
    import hrlp_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400000;

    // clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // item channel
    logic      in_valid = 1'b0;
    logic      in_ready;
    t_in_item  in_item  = '0;

    // result channel
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_item;

    // register write channel
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [7:0]             cfg_data  = '0;

    // stimulus and checking bookkeeping
    t_in_item    pending_chars[$];
    t_out_item   expected_results[$];
    int unsigned items_queued   = 0;
    int unsigned items_taken    = 0;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;
    logic        in_took        = 1'b0;
    logic        calm           = 1'b0;
    int unsigned gap_left       = 0;
    int unsigned stall_left     = 0;

    // predicted parser registers, reset values
    logic [7:0]  poll_limit = POLL_LIMIT_RST;
    logic [7:0]  line_limit = LINE_LIMIT_RST;

    // predicted per-line state, all zero after reset
    logic [1:0]  rec_kind    = PH_NONE;
    logic [7:0]  line_pos    = '0;
    logic [7:0]  poll_cnt    = '0;
    logic [3:0]  high_digit  = '0;
    logic [7:0]  rec_count   = '0;
    logic [15:0] rec_addr    = '0;
    logic [7:0]  data_idx    = '0;
    logic [2:0]  line_flags  = '0;
    logic        eof_seen    = 1'b0;

    hex_record_line_parser_top u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // 10 ns clock
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------------

    // value of a hex digit character, -1 for anything else
    function automatic int hex_nibble(input logic [7:0] c);
        if (c >= "0" && c <= "9") return c - "0";
        if (c >= "A" && c <= "F") return c - "A" + 10;
        if (c >= "a" && c <= "f") return c - "a" + 10;
        return -1;
    endfunction

    // status of the line as it stands now
    function automatic t_out_item line_status(input logic [2:0] k);
        t_out_item r;
        r.kind         = k;
        r.data_byte    = '0;
        r.load_address = rec_addr;
        r.byte_count   = rec_count;
        r.end_seen     = eof_seen;
        r.last         = 1'b0;
        return r;
    endfunction

    // everything but the sticky end flag goes back to zero
    task automatic restart_line();
        rec_kind   = PH_NONE;
        line_pos   = '0;
        poll_cnt   = '0;
        high_digit = '0;
        rec_count  = '0;
        rec_addr   = '0;
        data_idx   = '0;
        line_flags = '0;
    endtask

    // one accepted character or tick: update the line state and queue the
    // data byte and/or status that it produces
    task automatic parse_step(input t_in_item it);
        t_out_item  found [0:1];
        t_out_item  byte_res;
        int         nfound;
        logic [7:0] pos;
        logic [7:0] c;
        int         raw;
        logic [3:0] digit;
        logic       used;
        logic       ended;
        logic [2:0] status;
        nfound = 0;
        ended  = 1'b0;
        c      = it.char_code;
        if (poll_limit == 8'd0) begin
            // zero limit: every transfer times out at once
            found[nfound] = line_status(KIND_TIMEOUT);
            nfound++;
            restart_line();
        end else begin
            if (it.opcode == OP_CHAR) begin
                pos   = line_pos;
                raw   = hex_nibble(c);
                digit = (raw < 0) ? 4'd0 : 4'(raw);
                used  = 1'b0;
                if (pos == 8'd0) begin
                    if (c != CH_COLON) line_flags[FLAG_BAD_START] = 1'b1;
                end else if (!line_flags[FLAG_BAD_START]) begin
                    if (pos <= 8'd2) begin
                        // count digits
                        rec_count = {rec_count[3:0], digit};
                        used      = 1'b1;
                    end else if (pos <= 8'd6) begin
                        // address digits
                        rec_addr = {rec_addr[11:0], digit};
                        used     = 1'b1;
                    end else if (pos == 8'd7) begin
                        if (c == CH_ZERO) line_flags[FLAG_TYPE_ZERO] = 1'b1;
                    end else if (pos == 8'd8) begin
                        if (line_flags[FLAG_TYPE_ZERO] && c == CH_ZERO) begin
                            rec_kind = PH_DATA;
                        end else if (line_flags[FLAG_TYPE_ZERO] && c == CH_ONE) begin
                            rec_kind = PH_END;
                        end else begin
                            rec_kind = PH_OTHER;
                        end
                    end else if (rec_kind == PH_DATA && data_idx < rec_count
                                 && c != CH_LF) begin
                        // data digits, odd positions hold the high nibble
                        used = 1'b1;
                        if (pos[0]) begin
                            high_digit = digit;
                        end else begin
                            byte_res              = line_status(KIND_DATA);
                            byte_res.data_byte    = {high_digit, digit};
                            byte_res.load_address = rec_addr + 16'(data_idx);
                            found[nfound]         = byte_res;
                            nfound++;
                            data_idx++;
                        end
                    end
                    if (used && raw < 0) line_flags[FLAG_NON_HEX] = 1'b1;
                end
                line_pos = pos + 8'd1;
                ended = (c == CH_LF) || (int'(line_pos) >= int'(line_limit) - 1);
                if (ended) begin
                    if (line_flags[FLAG_BAD_START]) begin
                        status = KIND_BAD;
                    end else if (rec_kind == PH_END) begin
                        eof_seen = 1'b1;
                        status   = KIND_END;
                    end else if (rec_kind == PH_DATA && c == CH_LF
                                 && !line_flags[FLAG_NON_HEX]
                                 && int'(pos) == 11 + 2 * int'(rec_count)) begin
                        status = KIND_OK;
                    end else begin
                        status = KIND_INVALID;
                    end
                    found[nfound] = line_status(status);
                    nfound++;
                    restart_line();
                end
            end
            if (!ended) begin
                poll_cnt = poll_cnt + 8'd1;
                if (poll_cnt >= poll_limit) begin
                    found[nfound] = line_status(KIND_TIMEOUT);
                    nfound++;
                    restart_line();
                end
            end
        end
        if (nfound > 0) found[nfound-1].last = 1'b1;
        for (int i = 0; i < nfound; i++) expected_results.push_back(found[i]);
    endtask

    // ------------------------------------------------------------------------
    // monitor: transfers are taken at the rising edge
    // ------------------------------------------------------------------------
    always @(posedge clk) begin : monitor
        t_out_item want;
        if (rst_n) begin
            // register writes change the prediction from the next transfer on
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_POLL_LIMIT) begin
                    poll_limit = cfg_data;
                end else if (cfg_index == CFG_LINE_LIMIT) begin
                    line_limit = cfg_data;
                end
            end
            // accepted item: predict before counting it as taken
            if (in_valid && in_ready) begin
                parse_step(in_item);
                items_taken++;
            end
            // accepted result: compare with the oldest prediction
            if (out_valid && out_ready) begin
                if (expected_results.size() == 0) begin
                    if (mismatch_count < 10) begin
                        $display("unexpected result: kind=%0d data=%02h addr=%04h cnt=%02h end=%0b last=%0b",
                                 out_item.kind, out_item.data_byte, out_item.load_address,
                                 out_item.byte_count, out_item.end_seen, out_item.last);
                    end
                    mismatch_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (out_item.kind !== want.kind
                        || out_item.data_byte !== want.data_byte
                        || out_item.load_address !== want.load_address
                        || out_item.byte_count !== want.byte_count
                        || out_item.end_seen !== want.end_seen
                        || out_item.last !== want.last) begin
                        if (mismatch_count < 10) begin
                            $display("result mismatch at %0t:", $realtime);
                            $display("  expected kind=%0d data=%02h addr=%04h cnt=%02h end=%0b last=%0b",
                                     want.kind, want.data_byte, want.load_address,
                                     want.byte_count, want.end_seen, want.last);
                            $display("  actual   kind=%0d data=%02h addr=%04h cnt=%02h end=%0b last=%0b",
                                     out_item.kind, out_item.data_byte, out_item.load_address,
                                     out_item.byte_count, out_item.end_seen, out_item.last);
                        end
                        mismatch_count++;
                    end
                end
            end
        end
        in_took <= in_valid && in_ready;
    end

    // ------------------------------------------------------------------------
    // driver: next item transfer chosen at the falling edge
    // ------------------------------------------------------------------------
    always @(negedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (in_valid && !in_took) begin
            // transfer still waiting, hold valid and payload
        end else if (gap_left != 0) begin
            in_valid <= 1'b0;
            gap_left <= gap_left - 1;
        end else if (!calm && pending_chars.size() != 0 && $urandom_range(0, 7) == 0) begin
            // start an idle burst of random length
            in_valid <= 1'b0;
            gap_left <= $urandom_range(0, 7);
        end else if (pending_chars.size() != 0) begin
            in_valid <= 1'b1;
            in_item  <= pending_chars.pop_front();
        end else begin
            in_valid <= 1'b0;
        end
    end

    // result side back-pressure in random bursts
    always @(negedge clk) begin
        if (stall_left != 0) begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
            out_ready  <= 1'b0;
            stall_left <= $urandom_range(0, 7);
        end else begin
            out_ready <= 1'b1;
        end
    end

    // watchdog
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------

    task automatic queue_item(input logic op, input logic [7:0] c);
        t_in_item it;
        it.opcode    = op;
        it.char_code = c;
        pending_chars.push_back(it);
        items_queued++;
    endtask

    // hex digit character, letters in random case
    function automatic logic [7:0] hex_char(input logic [3:0] v);
        if (v < 4'd10) return CH_ZERO + 8'(v);
        return (($urandom_range(0, 1) != 0) ? "A" : "a") + 8'(v) - 8'd10;
    endfunction

    // one record line with random content; about a third get broken
    task automatic queue_record();
        logic [7:0]  line[$];
        logic [7:0]  cnt;
        logic [15:0] addr;
        int unsigned nbytes;
        int unsigned keep;
        int unsigned pick;
        line = {};
        cnt  = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 40))
                                           : 8'($urandom_range(0, 6));
        if ($urandom_range(0, 39) == 0) cnt = 8'($urandom);
        // huge counts get a short data field and end up invalid
        nbytes = (cnt > 8'd40) ? $urandom_range(0, 30) : cnt;
        addr = ($urandom_range(0, 3) == 0) ? 16'hFFFF - 16'($urandom_range(0, 3))
                                           : 16'($urandom);
        line.push_back(CH_COLON);
        line.push_back(hex_char(cnt[7:4]));
        line.push_back(hex_char(cnt[3:0]));
        for (int i = 3; i >= 0; i--) line.push_back(hex_char(addr[4*i +: 4]));
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
            // end of file
            line.push_back(CH_ZERO);
            line.push_back(CH_ONE);
        end else if (pick == 1) begin
            // other known record types
            line.push_back(CH_ZERO);
            line.push_back(CH_ZERO + 8'($urandom_range(2, 5)));
        end else if (pick == 2) begin
            line.push_back(8'($urandom));
            line.push_back(8'($urandom));
        end else begin
            line.push_back(CH_ZERO);
            line.push_back(CH_ZERO);
        end
        for (int i = 0; i < nbytes; i++) begin
            line.push_back(hex_char(4'($urandom)));
            line.push_back(hex_char(4'($urandom)));
        end
        // checksum is never checked
        line.push_back(hex_char(4'($urandom)));
        line.push_back(hex_char(4'($urandom)));
        line.push_back(CH_LF);
        case ($urandom_range(0, 9))
            0: begin
                // one character replaced by any byte
                line[$urandom_range(0, line.size() - 1)] = 8'($urandom);
            end
            1: begin
                // cut short, sometimes closed by an early newline
                keep = $urandom_range(1, line.size() - 1);
                while (line.size() > keep) void'(line.pop_back());
                if ($urandom_range(0, 1) != 0) line.push_back(CH_LF);
            end
            2: begin
                // extra character before the newline
                line.insert(line.size() - 1, hex_char(4'($urandom)));
            end
            default: begin
            end
        endcase
        // occasional noise between lines
        if ($urandom_range(0, 7) == 0) begin
            repeat ($urandom_range(1, 4)) queue_item(1'($urandom), 8'($urandom));
        end
        foreach (line[i]) begin
            if ($urandom_range(0, 15) == 0) queue_item(OP_TICK, 8'($urandom));
            queue_item(OP_CHAR, line[i]);
        end
    endtask

    // all items taken and all results back, then some spare clocks
    task automatic wait_idle();
        while (items_taken != items_queued || expected_results.size() != 0) begin
            @(negedge clk);
        end
        repeat (8) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // new limits once the parser is idle, then random lines
    task automatic run_phase(input logic [7:0] polls, input logic [7:0] len,
                             input int unsigned n);
        int unsigned target;
        wait_idle();
        write_reg(CFG_POLL_LIMIT, polls);
        write_reg(CFG_LINE_LIMIT, len);
        target = items_queued + n;
        while (items_queued < target) queue_record();
    endtask

    initial begin
        string rec;
        rec = ":02FFFF00aBcD";
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: tick, empty line (bad start), data record whose second
        // byte wraps the address, checksum bytes at both extremes
        queue_item(OP_TICK, 8'hFF);
        queue_item(OP_CHAR, CH_LF);
        foreach (rec[i]) queue_item(OP_CHAR, rec[i]);
        queue_item(OP_CHAR, 8'hFF);
        queue_item(OP_CHAR, 8'h00);
        queue_item(OP_CHAR, CH_LF);

        // random lines under several limit settings
        run_phase(8'd255, 8'd255, 600);
        run_phase(8'd1,   8'd2,   80);
        run_phase(8'd0,   8'd1,   30);
        run_phase(8'd3,   8'd0,   40);
        run_phase(8'd20,  8'd14,  200);
        run_phase(8'd255, 8'd40,  300);

        // final stretch at full rate, no idling on either side
        wait_idle();
        calm = 1'b1;
        run_phase(8'd200, 8'd255, 650);
        wait_idle();

        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ----- hex_record_line_parser_top.f -----
rtl/core/hrlp_pkg.sv
rtl/core/hrlp_parse.sv
rtl/core/hrlp_out_fifo.sv
rtl/core/hex_record_line_parser_top.sv
dv/tb_hex_record_line_parser_top.sv
